// File: rtl/core/irc_lt_pkg.sv
// Shared types and constants for the chat-line tokeniser.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package irc_lt_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_PARAMS_DEF = 16;
    localparam int MAX_LINE_DEF   = 512;

    // Fixed field widths of the request and result channels
    localparam int BYTE_W    = 8;
    localparam int ROLE_W    = 2;
    localparam int IDX_W     = 4;
    localparam int RETRACT_W = 9;

    // Characters of interest
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_DROP  = 2'd0,
        ROLE_CMD   = 2'd1,
        ROLE_PARAM = 2'd2,
        ROLE_TRAIL = 2'd3
    } role_t;

    typedef enum logic [6:0] {
        PH_LEAD        = 7'b0000001,
        PH_PREFIX      = 7'b0000010,
        PH_AFTER       = 7'b0000100,
        PH_GAP         = 7'b0001000,
        PH_TOKEN       = 7'b0010000,
        PH_TRAIL_FIRST = 7'b0100000,
        PH_TRAIL       = 7'b1000000
    } phase_t;

    // Byte class flags from the decoder
    typedef struct packed {
        logic              is_space;
        logic              is_blank;
        logic              is_sep;
        logic              is_colon;
        logic [BYTE_W-1:0] upper;
    } byte_class_t;

    // One tagged result
    typedef struct packed {
        logic [BYTE_W-1:0]    out_byte;
        role_t                role;
        logic                 token_start;
        logic [IDX_W-1:0]     param_index;
        logic                 param_overflow;
        logic                 end_of_line;
        logic                 had_command;
        logic                 had_trailing;
        logic [RETRACT_W-1:0] retract_count;
    } result_t;

    // Parser status seen by the top level
    typedef struct packed {
        logic line_start;
        logic in_trailing;
    } parse_status_t;

endpackage

`default_nettype wire

// File: rtl/core/irc_lt_classify.sv
// Byte class decoder: blank, separator, colon, upper-case fold.
// Depends on irc_lt_pkg.
`default_nettype none

module irc_lt_classify (
    input  wire logic [irc_lt_pkg::BYTE_W-1:0] byte_i,
    output irc_lt_pkg::byte_class_t            cls_o
);
    import irc_lt_pkg::*;

    always_comb begin
        cls_o.is_space = (byte_i == CH_SPACE);
        cls_o.is_blank = (byte_i == CH_SPACE) || (byte_i == CH_TAB);
        // isspace: HT, LF, VT, FF, CR and space
        cls_o.is_sep   = (byte_i == CH_SPACE) || ((byte_i >= CH_TAB) && (byte_i <= CH_CR));
        cls_o.is_colon = (byte_i == CH_COLON);
        if ((byte_i >= CH_LC_A) && (byte_i <= CH_LC_Z)) begin
            cls_o.upper = byte_i & ~CASE_BIT;
        end else begin
            cls_o.upper = byte_i;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/irc_lt_phase.sv
// Parse state machine: phase, counters and flags, plus the tagged result.
// Depends on irc_lt_pkg.
`default_nettype none

module irc_lt_phase #(
    parameter int MAX_PARAMS = irc_lt_pkg::MAX_PARAMS_DEF,
    parameter int MAX_LINE   = irc_lt_pkg::MAX_LINE_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step_en,
    input  wire logic [irc_lt_pkg::BYTE_W-1:0] byte_i,
    input  wire logic                          last_i,
    input  irc_lt_pkg::byte_class_t            cls_i,
    output irc_lt_pkg::result_t                res_o,
    output irc_lt_pkg::parse_status_t          status_o
);
    import irc_lt_pkg::*;

    localparam int PARAM_LIMIT = (MAX_PARAMS < 16) ? MAX_PARAMS : 16;
    localparam int RETRACT_CAP = ((MAX_LINE - 1) < 511) ? (MAX_LINE - 1) : 511;
    localparam int CNT_W       = $clog2(PARAM_LIMIT + 2);
    localparam int PB_W        = $clog2(RETRACT_CAP + 1);

    localparam logic [CNT_W-1:0] CNT_LIMIT    = CNT_W'(PARAM_LIMIT);
    localparam logic [CNT_W-1:0] CNT_LIMIT_M1 = CNT_W'(PARAM_LIMIT - 1);
    localparam logic [PB_W-1:0]  PB_CAP       = PB_W'(RETRACT_CAP);

    phase_t           phase_reg, phase_next;
    logic             prior_reg, prior_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             seen_cmd_reg, seen_cmd_next;
    logic             seen_trail_reg, seen_trail_next;
    logic [PB_W-1:0]  pend_reg, pend_next;

    logic             do_body;
    logic             body_prior;
    logic             body_in_token;
    logic [CNT_W-1:0] idx_wide;

    always_comb begin
        phase_next      = phase_reg;
        prior_next      = prior_reg;
        cnt_next        = cnt_reg;
        seen_cmd_next   = seen_cmd_reg;
        seen_trail_next = seen_trail_reg;
        pend_next       = pend_reg;
        do_body         = 1'b0;
        body_prior      = prior_reg;
        body_in_token   = 1'b0;
        idx_wide        = '0;

        res_o                = '0;
        res_o.out_byte       = byte_i;
        res_o.role           = ROLE_DROP;
        res_o.end_of_line    = last_i;

        unique case (phase_reg) inside
            PH_PREFIX: begin
                // tabs do not end the prefix
                if (cls_i.is_space) begin
                    phase_next = PH_AFTER;
                end
            end
            PH_AFTER: begin
                if (!cls_i.is_blank) begin
                    do_body    = 1'b1;
                    body_prior = 1'b0;
                end
            end
            PH_GAP, PH_TOKEN: begin
                do_body       = 1'b1;
                body_in_token = (phase_reg == PH_TOKEN);
            end
            PH_TRAIL_FIRST, PH_TRAIL: begin
                res_o.role        = ROLE_TRAIL;
                res_o.token_start = (phase_reg == PH_TRAIL_FIRST);
                phase_next        = PH_TRAIL;
                if (cls_i.is_blank) begin
                    if (pend_reg < PB_CAP) begin
                        pend_next = pend_reg + 1'b1;
                    end
                end else begin
                    pend_next = '0;
                end
            end
            default: begin
                // line start, and any stray phase code
                phase_next = PH_LEAD;
                if (cls_i.is_colon) begin
                    phase_next = PH_PREFIX;
                end else if (!cls_i.is_blank) begin
                    do_body    = 1'b1;
                    body_prior = 1'b0;
                end
            end
        endcase

        if (do_body) begin
            if (cls_i.is_colon && body_prior) begin
                seen_trail_next = 1'b1;
                phase_next      = PH_TRAIL_FIRST;
                prior_next      = 1'b0;
            end else if (cls_i.is_sep) begin
                phase_next = PH_GAP;
                prior_next = cls_i.is_space;
            end else begin
                prior_next = 1'b0;
                if (!body_in_token) begin
                    res_o.token_start = 1'b1;
                    phase_next        = PH_TOKEN;
                    if (!seen_cmd_reg) begin
                        seen_cmd_next = 1'b1;
                    end else if (cnt_reg <= CNT_LIMIT) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                if (cnt_next == '0) begin
                    res_o.role     = ROLE_CMD;
                    res_o.out_byte = cls_i.upper;
                end else begin
                    res_o.role = ROLE_PARAM;
                    idx_wide   = cnt_next - 1'b1;
                    if (idx_wide > CNT_LIMIT_M1) begin
                        idx_wide = CNT_LIMIT_M1;
                    end
                end
            end
        end

        res_o.param_index    = IDX_W'(idx_wide);
        res_o.param_overflow = (cnt_next > CNT_LIMIT);

        if (last_i) begin
            res_o.had_command   = seen_cmd_next;
            res_o.had_trailing  = seen_trail_next;
            res_o.retract_count = RETRACT_W'(pend_next);
            phase_next      = PH_LEAD;
            prior_next      = 1'b0;
            cnt_next        = '0;
            seen_cmd_next   = 1'b0;
            seen_trail_next = 1'b0;
            pend_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LEAD;
            prior_reg      <= 1'b0;
            cnt_reg        <= '0;
            seen_cmd_reg   <= 1'b0;
            seen_trail_reg <= 1'b0;
            pend_reg       <= '0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            prior_reg      <= prior_next;
            cnt_reg        <= cnt_next;
            seen_cmd_reg   <= seen_cmd_next;
            seen_trail_reg <= seen_trail_next;
            pend_reg       <= pend_next;
        end
    end

    assign status_o.line_start  = (phase_reg == PH_LEAD) && !prior_reg && (cnt_reg == '0)
                                  && !seen_cmd_reg && !seen_trail_reg && (pend_reg == '0);
    assign status_o.in_trailing = (phase_reg == PH_TRAIL_FIRST) || (phase_reg == PH_TRAIL);

endmodule

`default_nettype wire

// File: rtl/core/irc_line_tokenizer_unit.sv
// Chat-line tokeniser: one byte request in, one tagged byte out.
// Pipeline: a request passes the input register, then the result register, before
// m_valid rises; while the result slot stays full, it waits in the input register.
// Throughput: one byte per cycle unless m_ready stalls; parse state steps per byte.
// Reset: aresetn synchronous, active low; clears both valid flags and returns the
// parser to line start. Depends on irc_lt_pkg, irc_lt_classify, irc_lt_phase.
`default_nettype none

module irc_line_tokenizer_unit #(
    parameter int MAX_PARAMS = irc_lt_pkg::MAX_PARAMS_DEF,
    parameter int MAX_LINE   = irc_lt_pkg::MAX_LINE_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // request channel
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [irc_lt_pkg::BYTE_W-1:0]    s_in_byte,
    input  wire logic                             s_line_last,
    // result channel
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [irc_lt_pkg::BYTE_W-1:0]         m_out_byte,
    output logic [irc_lt_pkg::ROLE_W-1:0]         m_role,
    output logic                                  m_token_start,
    output logic [irc_lt_pkg::IDX_W-1:0]          m_param_index,
    output logic                                  m_param_overflow,
    output logic                                  m_end_of_line,
    output logic                                  m_had_command,
    output logic                                  m_had_trailing,
    output logic [irc_lt_pkg::RETRACT_W-1:0]      m_retract_count
);
    import irc_lt_pkg::*;

    // Input register stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Result register stage
    logic    out_valid_reg;
    result_t out_reg;

    // A byte moves from the input register into the result register (and the
    // parse state steps) whenever the result slot is free or being emptied.
    logic          step;
    byte_class_t   cls;
    result_t       res;
    parse_status_t status;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    // The input register refills in the same cycle it drains.
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload only: no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_line_last;
        end
    end

    irc_lt_classify u_classify (
        .byte_i (in_byte_reg),
        .cls_o  (cls)
    );

    irc_lt_phase #(
        .MAX_PARAMS (MAX_PARAMS),
        .MAX_LINE   (MAX_LINE)
    ) u_phase (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step),
        .byte_i   (in_byte_reg),
        .last_i   (in_last_reg),
        .cls_i    (cls),
        .res_o    (res),
        .status_o (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_out_byte       = out_reg.out_byte;
    assign m_role           = out_reg.role;
    assign m_token_start    = out_reg.token_start;
    assign m_param_index    = out_reg.param_index;
    assign m_param_overflow = out_reg.param_overflow;
    assign m_end_of_line    = out_reg.end_of_line;
    assign m_had_command    = out_reg.had_command;
    assign m_had_trailing   = out_reg.had_trailing;
    assign m_retract_count  = out_reg.retract_count;

    // After a line's final byte the parser is back at line start.
    a_line_end_resets : assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_last_reg |=> status.line_start)
        else $error("parser not at line start after line end");

    // A stalled input register keeps its byte until it can step.
    a_input_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_byte_reg)
                                  && $stable(in_last_reg))
        else $error("input register lost a request while stalled");

    // Every step lands in the result register.
    a_step_to_result : assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("stepped byte produced no result");

    // Trailing text tag only while the parser sits in the trailing phases.
    a_trail_phase : assert property (@(posedge aclk) disable iff (!aresetn)
        step && (res.role == ROLE_TRAIL) |-> status.in_trailing)
        else $error("trailing tag outside trailing phase");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the chat-line tokeniser (irc_line_tokenizer_unit).
// Depends on irc_lt_pkg and the RTL under rtl/core; needs no files or arguments.

module tb_top;
    import irc_lt_pkg::*;

    // Default parameters of the block, mirrored for the byte tagger below
    localparam int PARAM_LIMIT  = (MAX_PARAMS_DEF < 16) ? MAX_PARAMS_DEF : 16;
    localparam int RETRACT_CAP  = ((MAX_LINE_DEF - 1) < 511) ? (MAX_LINE_DEF - 1) : 511;
    localparam int LONG_HOLD    = 64;      // receiver hold-off in the back-pressure test
    localparam int LIMIT_CYCLES = 100000;  // watchdog, well above the slowest correct run
    localparam int SETTLE       = 6;       // pipeline depth plus margin at the end

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_in_byte   = '0;
    logic                 s_line_last = 1'b0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [BYTE_W-1:0]    m_out_byte;
    logic [ROLE_W-1:0]    m_role;
    logic                 m_token_start;
    logic [IDX_W-1:0]     m_param_index;
    logic                 m_param_overflow;
    logic                 m_end_of_line;
    logic                 m_had_command;
    logic                 m_had_trailing;
    logic [RETRACT_W-1:0] m_retract_count;

    irc_line_tokenizer_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_byte        (s_in_byte),
        .s_line_last      (s_line_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_role           (m_role),
        .m_token_start    (m_token_start),
        .m_param_index    (m_param_index),
        .m_param_overflow (m_param_overflow),
        .m_end_of_line    (m_end_of_line),
        .m_had_command    (m_had_command),
        .m_had_trailing   (m_had_trailing),
        .m_retract_count  (m_retract_count)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shared run state
    // ------------------------------------------------------------------
    result_t     tagged_q[$];      // expected tagged bytes, oldest first
    result_t     tag_work;         // result being built for the current byte
    result_t     tag_head;         // expectation popped by the checker
    logic [7:0]  line_buf[$];      // line under construction
    int          err_count   = 0;
    int          bytes_sent  = 0;
    int          cycle_count = 0;
    bit          src_idle_en  = 1'b0;
    bit          sink_idle_en = 1'b0;
    int          hold_reqs   = 0;  // bumped by a test to ask for a long receiver stall
    int          holds_done  = 0;

    // Local copy of the parser state
    phase_t      cur_phase;
    logic        last_was_space;
    logic [4:0]  param_count;
    logic        cmd_seen;
    logic        trail_seen;
    logic [8:0]  blank_run;

    // ------------------------------------------------------------------
    // Byte tagger: expected behaviour, one request at a time
    // ------------------------------------------------------------------
    function automatic bit is_blank_b(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    // isspace(): tab through CR, or space
    function automatic bit is_sep_b(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    task automatic clear_parse_state();
        cur_phase      = PH_LEAD;
        last_was_space = 1'b0;
        param_count    = '0;
        cmd_seen       = 1'b0;
        trail_seen     = 1'b0;
        blank_run      = '0;
    endtask

    // A byte inside the message body (command, parameters, separators)
    task automatic tag_body_byte(input logic [7:0] b);
        int pn;
        if (b == CH_COLON && last_was_space) begin
            // space-colon opens the trailing text; both bytes are dropped
            trail_seen     = 1'b1;
            cur_phase      = PH_TRAIL_FIRST;
            last_was_space = 1'b0;
        end else if (is_sep_b(b)) begin
            cur_phase      = PH_GAP;
            last_was_space = (b == CH_SPACE);
        end else begin
            last_was_space = 1'b0;
            if (cur_phase != PH_TOKEN) begin
                tag_work.token_start = 1'b1;
                cur_phase = PH_TOKEN;
                if (!cmd_seen)
                    cmd_seen = 1'b1;
                else if (param_count <= PARAM_LIMIT)
                    param_count = param_count + 1'b1;
            end
            if (param_count == 0) begin
                tag_work.role = ROLE_CMD;
                if (b >= CH_LC_A && b <= CH_LC_Z)
                    tag_work.out_byte = b & ~CASE_BIT;
            end else begin
                pn = param_count;
                tag_work.role = ROLE_PARAM;
                tag_work.param_index =
                    IDX_W'((pn - 1 < PARAM_LIMIT - 1) ? pn - 1 : PARAM_LIMIT - 1);
            end
        end
    endtask

    task automatic tag_byte(input logic [7:0] b, input logic last);
        tag_work          = '0;
        tag_work.out_byte = b;
        tag_work.role     = ROLE_DROP;
        case (cur_phase)
            PH_PREFIX: begin
                // only a real space ends the prefix
                if (b == CH_SPACE)
                    cur_phase = PH_AFTER;
            end
            PH_AFTER: begin
                if (!is_blank_b(b)) begin
                    last_was_space = 1'b0;
                    tag_body_byte(b);
                end
            end
            PH_GAP, PH_TOKEN: begin
                tag_body_byte(b);
            end
            PH_TRAIL_FIRST, PH_TRAIL: begin
                tag_work.role        = ROLE_TRAIL;
                tag_work.token_start = (cur_phase == PH_TRAIL_FIRST);
                cur_phase            = PH_TRAIL;
                if (is_blank_b(b)) begin
                    if (blank_run < RETRACT_CAP)
                        blank_run = blank_run + 1'b1;
                end else begin
                    blank_run = '0;
                end
            end
            default: begin
                // line start, and any unused phase code
                if (is_blank_b(b)) begin
                    cur_phase = PH_LEAD;
                end else if (b == CH_COLON) begin
                    cur_phase = PH_PREFIX;
                end else begin
                    cur_phase      = PH_LEAD;
                    last_was_space = 1'b0;
                    tag_body_byte(b);
                end
            end
        endcase
        tag_work.param_overflow = (param_count > PARAM_LIMIT);
        tag_work.end_of_line    = last;
        if (last) begin
            tag_work.had_command   = cmd_seen;
            tag_work.had_trailing  = trail_seen;
            tag_work.retract_count = blank_run;
            clear_parse_state();
        end
        tagged_q.insert(tagged_q.size(), tag_work);
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_in_byte   <= b;
        s_line_last <= last;
        do
            @(posedge aclk);
        while (!s_ready);
        bytes_sent++;
        tag_byte(b, last);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_line_buf();
        int i;
        for (i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        while (tagged_q.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Line generators
    // ------------------------------------------------------------------
    task automatic add_line_byte(input logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endtask

    // Bias towards the bytes the parser cares about, plus fold boundaries
    function automatic logic [7:0] any_byte();
        if ($urandom_range(0, 2) != 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 14))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return 8'h0A;
            3:       return 8'h0B;
            4:       return 8'h0C;
            5:       return CH_CR;
            6:       return CH_COLON;
            7:       return CH_LC_A;
            8:       return CH_LC_Z;
            9:       return CH_LC_A - 8'd1;
            10:      return CH_LC_Z + 8'd1;
            11:      return 8'h00;
            12:      return 8'hFF;
            13:      return 8'h08;
            default: return 8'h0E;
        endcase
    endfunction

    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        b = any_byte();
        while (is_sep_b(b))
            b = any_byte();
        return b;
    endfunction

    function automatic logic [7:0] sep_byte();
        if ($urandom_range(0, 2) != 0)
            return CH_SPACE;
        return 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    function automatic logic [7:0] blank_byte();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] cmd_byte();
        case ($urandom_range(0, 3))
            0:       return 8'(CH_LC_A + $urandom_range(0, 25));
            1:       return 8'(CH_LC_A + $urandom_range(0, 25) - CASE_BIT);
            2:       return 8'(8'h30 + $urandom_range(0, 9));
            default: return word_byte();
        endcase
    endfunction

    // [blanks] [:prefix SP [blanks]] command {sep param} [SP : trailing [blanks]]
    task automatic build_message_line();
        int np;
        line_buf.delete();
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) add_line_byte(blank_byte());
        if ($urandom_range(0, 3) == 0) begin
            add_line_byte(CH_COLON);
            repeat ($urandom_range(1, 4)) add_line_byte(word_byte());
            if ($urandom_range(0, 9) == 0)
                return;     // prefix never closed: the rest is dropped
            add_line_byte(CH_SPACE);
            repeat ($urandom_range(0, 2)) add_line_byte(blank_byte());
        end
        repeat ($urandom_range(1, 5)) add_line_byte(cmd_byte());
        np = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
        repeat (np) begin
            repeat ($urandom_range(1, 2)) add_line_byte(sep_byte());
            repeat ($urandom_range(1, 4)) add_line_byte(word_byte());
        end
        if ($urandom_range(0, 1)) begin
            add_line_byte(CH_SPACE);
            add_line_byte(CH_COLON);
            repeat ($urandom_range(0, 6)) add_line_byte(any_byte());
            repeat ($urandom_range(0, 3)) add_line_byte(blank_byte());
        end else begin
            repeat ($urandom_range(0, 1)) add_line_byte(sep_byte());
        end
    endtask

    task automatic build_noise_line();
        line_buf.delete();
        repeat ($urandom_range(1, 10)) add_line_byte(any_byte());
    endtask

    task automatic send_random_line();
        if ($urandom_range(0, 9) == 0)
            build_noise_line();
        else
            build_message_line();
        send_line_buf();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Byte extremes, every role and the awkward corners of the grammar
    task automatic test_directed_lines();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_text(":p");                // prefix with no space: nothing left
        send_text(":p :X");             // colon straight after prefix is a command byte
        send_text("\013 :t \t");        // trailing opens before any command
        send_text("\tjoin #c :hi ");    // folded command, one parameter, trailing
    endtask

    task automatic test_random_lines();
        while (bytes_sent < 620)
            send_random_line();
    endtask

    // Over 511 trailing blanks so the retract count saturates
    task automatic test_retract_saturation();
        line_buf.delete();
        add_line_byte("Q");
        add_line_byte(CH_SPACE);
        add_line_byte(CH_COLON);
        add_line_byte("b");
        repeat (RETRACT_CAP + 8) add_line_byte(blank_byte());
        send_line_buf();
    endtask

    // Receiver stalls for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        hold_reqs++;
        repeat (4) send_random_line();
        drain_results();
    endtask

    // Sender goes quiet until the pipe is empty, then resumes
    task automatic test_sender_pause();
        repeat (3) begin
            send_random_line();
            drain_results();
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_burst_no_idle();
        int stop_at;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        stop_at = bytes_sent + 250;
        while (bytes_sent < stop_at)
            send_random_line();
    endtask

    // ------------------------------------------------------------------
    // Result side: ready generator and checker
    // ------------------------------------------------------------------
    int hold_left = 0;
    int gap_left  = 0;

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_reqs != holds_done) begin
            holds_done = holds_done + 1;
            hold_left  = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            m_ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(1, 3) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (tagged_q.size() == 0) begin
                $error("result with nothing expected: out_byte 0x%0h", m_out_byte);
                err_count++;
            end else begin
                tag_head = tagged_q.pop_front();
                check_field("out_byte",       tag_head.out_byte,       m_out_byte);
                check_field("role",           tag_head.role,           m_role);
                check_field("token_start",    tag_head.token_start,    m_token_start);
                check_field("param_index",    tag_head.param_index,    m_param_index);
                check_field("param_overflow", tag_head.param_overflow, m_param_overflow);
                check_field("end_of_line",    tag_head.end_of_line,    m_end_of_line);
                check_field("had_command",    tag_head.had_command,    m_had_command);
                check_field("had_trailing",   tag_head.had_trailing,   m_had_trailing);
                check_field("retract_count",  tag_head.retract_count,  m_retract_count);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_parse_state();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;

        test_directed_lines();
        test_random_lines();
        test_retract_saturation();
        test_output_backpressure();
        test_sender_pause();
        test_burst_no_idle();

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
